### rtl/core/gds_pkg.sv
// shared types, codes and constants of the genotype dosage stream decoder
package gds_pkg;

    localparam int SAMPLES_MAX_DEF = 65536;
    localparam int DIV_STEPS       = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALLELES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN  = 3'd4;

    // sample status codes
    localparam logic [1:0] SS_VALID   = 2'd0;
    localparam logic [1:0] SS_MISSING = 2'd1;
    localparam logic [1:0] SS_INVALID = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE            = 3'd0;
    localparam logic [2:0] ERR_COMPRESSED      = 3'd1;
    localparam logic [2:0] ERR_NOT_BIALLELIC   = 3'd2;
    localparam logic [2:0] ERR_TOO_SMALL       = 3'd3;
    localparam logic [2:0] ERR_SAMPLE_MISMATCH = 3'd4;
    localparam logic [2:0] ERR_ALLELE_MISMATCH = 3'd5;
    localparam logic [2:0] ERR_BAD_WIDTH       = 3'd6;
    localparam logic [2:0] ERR_OVERRUN         = 3'd7;

    localparam logic [15:0] BIALLELIC = 16'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    typedef enum logic [3:0] {
        PH_HEAD  = 4'b0001,
        PH_D11   = 4'b0010,
        PH_D12   = 4'b0100,
        PH_DRAIN = 4'b1000
    } t_phase;

    typedef struct packed {
        logic        layout_mode;
        logic        compressed_input;
        logic [16:0] sample_count;
        logic [15:0] allele_count;
        logic [19:0] block_bytes;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic got;
        logic need_div;
        logic div_last;
    } t_dp_sts;

endpackage

### rtl/core/gds_in_if.sv
// byte input channel
interface gds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

### rtl/core/gds_out_if.sv
// dosage result channel
interface gds_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_index;
    logic [31:0] dosage;
    logic [1:0]  sample_status;
    logic [2:0]  error_code;
    logic        end_of_block;

    modport source (output valid, output sample_index, output dosage, output sample_status,
                    output error_code, output end_of_block, input ready);
    modport sink   (input valid, input sample_index, input dosage, input sample_status,
                    input error_code, input end_of_block, output ready);
endinterface

### rtl/core/genotype_dosage_stream_core.sv
// Genotype block dosage decoder: takes one byte of an uncompressed biallelic genotype
// block (layout 1.1 or 1.2) per cycle while idle and returns one Q2.30 dosage item per
// sample, or one error item that ends the block. A byte that yields no result leaves the
// core idle; a missing, invalid or error item goes to the output register; a dosage first
// runs the bit-serial divider (32 steps). Items wait in the output register while the
// output side stalls. Missing marks are held in a SAMPLES_MAX x 1 memory with no clearing
// pass; configuration must be written by the user while idle; the core does not enforce it.
module genotype_dosage_stream_core #(
    parameter int SAMPLES_MAX = gds_pkg::SAMPLES_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gds_in_if.sink                         i_in,
    gds_out_if.source                      o_out
);

    gds_pkg::t_cfg    r_cfg;
    gds_pkg::t_dp_cmd cmd;
    gds_pkg::t_dp_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layout_mode      <= 1'b1;
            r_cfg.compressed_input <= 1'b0;
            r_cfg.sample_count     <= '0;
            r_cfg.allele_count     <= gds_pkg::BIALLELIC;
            r_cfg.block_bytes      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gds_pkg::REG_LAYOUT:     r_cfg.layout_mode      <= i_cfg_data[0];
                gds_pkg::REG_COMPRESSED: r_cfg.compressed_input <= i_cfg_data[0];
                gds_pkg::REG_SAMPLES:    r_cfg.sample_count     <= i_cfg_data[16:0];
                gds_pkg::REG_ALLELES:    r_cfg.allele_count     <= i_cfg_data[15:0];
                gds_pkg::REG_BLOCK_LEN:  r_cfg.block_bytes      <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    gds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    gds_datapath #(
        .SAMPLES_MAX (SAMPLES_MAX)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_byte   (i_in.data_byte),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_idx    (o_out.sample_index),
        .o_dosage (o_out.dosage),
        .o_status (o_out.sample_status),
        .o_err    (o_out.error_code),
        .o_eob    (o_out.end_of_block)
    );

endmodule

### rtl/core/gds_ctrl.sv
// handshake and divider sequencing state machine
module gds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  gds_pkg::t_dp_sts i_sts,
    output gds_pkg::t_dp_cmd o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);

    gds_pkg::t_state r_state, n_state;
    logic            take;

    assign o_in_ready  = (r_state == gds_pkg::ST_IDLE);
    assign o_out_valid = (r_state == gds_pkg::ST_OUT);
    assign take        = i_in_valid & o_in_ready;
    assign o_cmd.take  = take;
    assign o_cmd.step  = (r_state == gds_pkg::ST_DIV);

    always_comb begin
        n_state = r_state;
        case (r_state)
            gds_pkg::ST_IDLE: begin
                if (take) begin
                    if (i_sts.need_div) n_state = gds_pkg::ST_DIV;
                    else if (i_sts.got) n_state = gds_pkg::ST_OUT;
                end
            end
            gds_pkg::ST_DIV: begin
                if (i_sts.div_last) n_state = gds_pkg::ST_OUT;
            end
            gds_pkg::ST_OUT: begin
                if (i_out_ready) n_state = gds_pkg::ST_IDLE;
            end
            default: n_state = gds_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= gds_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready)) else $error("in ready while result pending");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_sts.need_div) |=> (r_state == gds_pkg::ST_DIV))
        else $error("division not started");
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gds_pkg::ST_DIV && i_sts.div_last) |=> o_out_valid)
        else $error("quotient not presented");

endmodule

### rtl/core/gds_datapath.sv
// byte parser, missing-mark memory, bit-serial divider and result registers
module gds_datapath #(
    parameter int SAMPLES_MAX = gds_pkg::SAMPLES_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gds_pkg::t_cfg    i_cfg,
    input  logic [7:0]       i_byte,
    input  gds_pkg::t_dp_cmd i_cmd,
    output gds_pkg::t_dp_sts o_sts,
    output logic [15:0]      o_idx,
    output logic [31:0]      o_dosage,
    output logic [1:0]       o_status,
    output logic [2:0]       o_err,
    output logic             o_eob
);

    localparam int          AW  = (SAMPLES_MAX > 1) ? $clog2(SAMPLES_MAX) : 1;
    localparam logic [21:0] LIM = 22'(SAMPLES_MAX);

    function automatic logic [63:0] f_merge(logic [63:0] win, logic [7:0] b, logic [2:0] off);
        logic [63:0] ext;
        ext = {56'b0, b} << {off, 3'b000};
        f_merge = (off == 3'd0) ? {56'b0, b} : (win | ext);
    endfunction

    // parser state
    gds_pkg::t_phase r_phase, n_phase;
    logic [19:0]     r_pos, n_pos;
    logic [47:0]     r_hdr, n_hdr;
    logic [63:0]     r_sw, n_sw;
    logic [1:0]      r_wc, n_wc;
    logic [16:0]     r_cnt, n_cnt;
    logic [2:0]      r_off6, n_off6;

    // result and divider
    logic [15:0] r_idx;
    logic [1:0]  r_stat;
    logic [2:0]  r_err;
    logic        r_eob;
    logic [31:0] r_q, r_rem, r_den;
    logic [4:0]  r_dcnt;

    // marks
    logic          mem_mark [0:SAMPLES_MAX-1];
    logic          r_mark;
    logic          mark_we;
    logic [AW-1:0] mark_waddr;

    // comb
    gds_pkg::t_phase ph;
    logic [21:0] n22, len22, pos22, n6, need12;
    logic        fail_now, fin, got, need_div, last, refit, miss;
    logic [2:0]  err, off12, mask12, rel3;
    logic [1:0]  stat;
    logic [33:0] num;
    logic [31:0] den, aa32, ab32, m32, bb32;
    logic [32:0] sum33;
    logic [17:0] sum18;
    logic [63:0] w;
    logic [63:0] hdr64;
    logic [47:0] hdr_cur;
    logic [1:0]  wc_new;
    logic        eob;

    always_comb begin
        n22      = 22'(i_cfg.sample_count);
        len22    = (i_cfg.block_bytes == 20'd0) ? 22'd1 : 22'(i_cfg.block_bytes);
        pos22    = 22'(r_pos);
        n6       = (n22 << 2) + (n22 << 1);
        refit    = (22'(i_cfg.block_bytes) == n6);
        ph       = r_phase;
        fail_now = 1'b0;
        fin      = 1'b0;
        need_div = 1'b0;
        err      = gds_pkg::ERR_NONE;
        stat     = gds_pkg::SS_VALID;
        num      = '0;
        den      = '0;
        n_hdr    = r_hdr;
        n_sw     = r_sw;
        n_wc     = r_wc;
        n_cnt    = r_cnt;
        mark_we  = 1'b0;
        mark_waddr = AW'(r_pos - 20'd8);
        hdr64    = f_merge({16'b0, r_hdr}, i_byte, r_pos[2:0]);
        hdr_cur  = hdr64[47:0];
        wc_new   = 2'd0;
        need12   = '0;
        w        = '0;
        aa32 = '0; ab32 = '0; m32 = '0; bb32 = '0; sum33 = '0; sum18 = '0;
        miss     = 1'b0;
        rel3     = r_pos[2:0] - i_cfg.sample_count[2:0] - 3'd2;
        mask12   = (r_wc == 2'd0) ? 3'd1 : ((r_wc == 2'd1) ? 3'd3 : 3'd7);
        off12    = rel3 & mask12;

        // checks at the first byte of a block
        if (r_phase == gds_pkg::PH_HEAD && r_pos == 20'd0) begin
            if (i_cfg.compressed_input) begin
                fail_now = 1'b1; err = gds_pkg::ERR_COMPRESSED;
            end else if (!i_cfg.layout_mode) begin
                if (len22 < n6) begin
                    fail_now = 1'b1; err = gds_pkg::ERR_TOO_SMALL;
                end else begin
                    ph = (n22 != 22'd0) ? gds_pkg::PH_D11 : gds_pkg::PH_DRAIN;
                end
            end else if (i_cfg.allele_count != gds_pkg::BIALLELIC) begin
                fail_now = 1'b1; err = gds_pkg::ERR_NOT_BIALLELIC;
            end else if (len22 < 22'd10) begin
                fail_now = 1'b1; err = gds_pkg::ERR_TOO_SMALL;
            end
        end
        if (fail_now) ph = gds_pkg::PH_DRAIN;

        if (ph == gds_pkg::PH_HEAD) begin
            if (r_pos < 20'd6) begin
                n_hdr = hdr_cur;
                n_sw  = f_merge(r_sw, i_byte, r_pos[2:0]);
            end
            if (r_pos == 20'd3) begin
                if (hdr_cur[31:0] != 32'(i_cfg.sample_count)) begin
                    if (refit) ph = gds_pkg::PH_D11;
                    else begin
                        fail_now = 1'b1; err = gds_pkg::ERR_SAMPLE_MISMATCH;
                        ph = gds_pkg::PH_DRAIN;
                    end
                end
            end else if (r_pos == 20'd5) begin
                if (hdr_cur[47:32] != i_cfg.allele_count) begin
                    if (refit) ph = gds_pkg::PH_D11;
                    else begin
                        fail_now = 1'b1; err = gds_pkg::ERR_ALLELE_MISMATCH;
                        ph = gds_pkg::PH_DRAIN;
                    end
                end
            end else if (r_pos == 20'd7) begin
                if (n22 + 22'd10 > len22) begin
                    fail_now = 1'b1; err = gds_pkg::ERR_OVERRUN;
                    ph = gds_pkg::PH_DRAIN;
                end
            end else if (r_pos >= 20'd8) begin
                if (pos22 < n22 + 22'd8) begin
                    mark_we = (pos22 - 22'd8) < LIM;
                end else if (pos22 == n22 + 22'd9) begin
                    wc_new = (i_byte == 8'd16) ? 2'd1 : ((i_byte == 8'd32) ? 2'd2 : 2'd0);
                    need12 = n22 + 22'd10 + (n22 << (wc_new + 2'd1));
                    if (i_byte != 8'd8 && i_byte != 8'd16 && i_byte != 8'd32) begin
                        fail_now = 1'b1; err = gds_pkg::ERR_BAD_WIDTH;
                        ph = gds_pkg::PH_DRAIN;
                    end else begin
                        n_wc = wc_new;
                        if (need12 > len22) begin
                            fail_now = 1'b1; err = gds_pkg::ERR_OVERRUN;
                            ph = gds_pkg::PH_DRAIN;
                        end else begin
                            n_cnt = '0;
                            ph = (n22 != 22'd0) ? gds_pkg::PH_D12 : gds_pkg::PH_DRAIN;
                        end
                    end
                end else if (pos22 > n22 + 22'd9) begin
                    ph = gds_pkg::PH_DRAIN;
                end
            end
        end

        if (ph == gds_pkg::PH_D11) begin
            w    = f_merge(n_sw, i_byte, r_off6);
            n_sw = w;
            if (r_off6 == 3'd5) begin
                fin   = 1'b1;
                sum18 = 18'(w[15:0]) + 18'(w[31:16]) + 18'(w[47:32]);
                if (sum18 == 18'd0) stat = gds_pkg::SS_MISSING;
                else begin
                    need_div = 1'b1;
                    num = 34'(w[31:16]) + (34'(w[47:32]) << 1);
                    den = 32'(sum18);
                end
            end
        end else if (r_phase == gds_pkg::PH_D12) begin
            w    = f_merge(r_sw, i_byte, off12);
            n_sw = w;
            if (off12 == mask12) begin
                fin = 1'b1;
                case (r_wc)
                    2'd0: begin
                        aa32 = 32'(w[7:0]);  ab32 = 32'(w[15:8]);  m32 = 32'd255;
                    end
                    2'd1: begin
                        aa32 = 32'(w[15:0]); ab32 = 32'(w[31:16]); m32 = 32'd65535;
                    end
                    default: begin
                        aa32 = w[31:0];      ab32 = w[63:32];      m32 = 32'hFFFF_FFFF;
                    end
                endcase
                sum33 = 33'(aa32) + 33'(ab32);
                bb32  = m32 - aa32 - ab32;
                miss  = (22'(r_cnt) < LIM) ? r_mark : 1'b0;
                if (miss) stat = gds_pkg::SS_MISSING;
                else if (sum33 > 33'(m32)) stat = gds_pkg::SS_INVALID;
                else begin
                    need_div = 1'b1;
                    num = 34'(ab32) + (34'(bb32) << 1);
                    den = m32;
                end
            end
        end

        eob = 1'b0;
        if (fin) begin
            n_cnt = r_cnt + 17'd1;
            if (n_cnt >= i_cfg.sample_count) begin
                ph  = gds_pkg::PH_DRAIN;
                eob = 1'b1;
            end
        end
        // an error item always ends the block
        if (fail_now) eob = 1'b1;
        got = fail_now | fin;

        last = (pos22 + 22'd1 >= len22);
        if (last) begin
            if (got) eob = 1'b1;
            n_phase = gds_pkg::PH_HEAD;
            n_pos   = '0;
            n_hdr   = '0;
            n_sw    = '0;
            n_wc    = '0;
            n_cnt   = '0;
            n_off6  = '0;
        end else begin
            n_phase = ph;
            n_pos   = r_pos + 20'd1;
            n_off6  = (r_off6 == 3'd5) ? 3'd0 : r_off6 + 3'd1;
        end
    end

    assign o_sts.got      = got;
    assign o_sts.need_div = need_div;
    assign o_sts.div_last = (r_dcnt == 5'(gds_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gds_pkg::PH_HEAD;
            r_pos   <= '0;
            r_hdr   <= '0;
            r_sw    <= '0;
            r_wc    <= '0;
            r_cnt   <= '0;
            r_off6  <= '0;
        end else if (i_cmd.take) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_hdr   <= n_hdr;
            r_sw    <= n_sw;
            r_wc    <= n_wc;
            r_cnt   <= n_cnt;
            r_off6  <= n_off6;
        end
    end

    // mark memory: the read address follows the sample counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && mark_we) mem_mark[mark_waddr] <= i_byte[7];
        r_mark <= mem_mark[AW'(r_cnt)];
    end

    // restoring division, one quotient bit per cycle; the upper quotient bits are known zero
    logic [32:0] rem2;
    logic        ge;
    assign rem2 = {r_rem, r_q[31]};
    assign ge   = (rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_idx  <= fail_now ? 16'd0 : r_cnt[15:0];
            r_stat <= stat;
            r_err  <= err;
            r_eob  <= eob;
            r_den  <= den;
            r_rem  <= num[33:2];
            r_q    <= need_div ? {num[1:0], 30'b0} : 32'd0;
            r_dcnt <= '0;
        end else if (i_cmd.step) begin
            r_rem  <= ge ? 32'(rem2 - {1'b0, r_den}) : rem2[31:0];
            r_q    <= {r_q[30:0], ge};
            r_dcnt <= r_dcnt + 5'd1;
        end
    end

    assign o_idx    = r_idx;
    assign o_dosage = r_q;
    assign o_status = r_stat;
    assign o_err    = r_err;
    assign o_eob    = r_eob;

    a_wc_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == gds_pkg::PH_D12) |-> (r_wc != 2'd3)) else $error("bad width code");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != 20'd0) |-> (r_phase != gds_pkg::PH_HEAD || r_off6 < 3'd6))
        else $error("offset counter out of range");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rem < r_den)) else $error("divider remainder overflow");

endmodule

### sim/genotype_dosage_stream_core_tb.sv
// testbench for the genotype dosage stream decoder: byte stream in, checked dosage items out
module genotype_dosage_stream_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BYTES = 1100;

    typedef struct packed {
        logic [15:0] idx;
        logic [31:0] dos;
        logic [1:0]  st;
        logic [2:0]  err;
        logic        eob;
    } t_dosage;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [gds_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [gds_pkg::CFG_DATA_W-1:0] i_cfg_data;

    gds_in_if  in_ch ();
    gds_out_if out_ch ();

    genotype_dosage_stream_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // register mirror
    logic        cfg_layout;
    logic        cfg_comp;
    logic [16:0] cfg_samples;
    logic [15:0] cfg_alleles;
    logic [19:0] cfg_len;

    // decoder state mirror
    logic [19:0]     pos_q;
    gds_pkg::t_phase phase;
    logic [47:0]     hdr_win;
    logic [63:0]     smp_win;
    logic [1:0]      wcode;
    logic [16:0]     smp_cnt;
    bit              marks [0:65535];
    logic            fallback;
    logic            failed;

    logic [7:0] byte_q [$];
    t_dosage    dosage_q [$];

    int  bytes_sent = 0;
    int  blk_left = 0;
    int  send_gap = 0;
    int  stall = 0;
    int  idle_cyc = 0;
    int  fail_cnt = 0;
    int  took_cnt = 0;
    int  seen_cnt = 0;
    bit  quiet = 0;
    bit  hold_req = 0;
    bit  hold_seen = 0;
    bit  hold_done = 0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic block_restart();
        pos_q = '0;
        phase = gds_pkg::PH_HEAD;
        hdr_win = '0;
        smp_win = '0;
        wcode = '0;
        smp_cnt = '0;
        fallback = 1'b0;
        failed = 1'b0;
    endtask

    task automatic block_fail(input logic [2:0] code, output t_dosage r);
        phase = gds_pkg::PH_DRAIN;
        failed = 1'b1;
        r = '0;
        r.err = code;
        r.eob = 1'b1;
    endtask

    // works out the result that one accepted byte causes
    task automatic decode_byte(input logic [7:0] b);
        logic [63:0]     n, len, bw, aa, ab, bb, sum, m;
        logic [19:0]     pos;
        gds_pkg::t_phase ph0;
        logic            got, refit, miss;
        t_dosage         r;
        int unsigned     nbytes, stride, off, bits;
        n = 64'(cfg_samples);
        len = (cfg_len != 0) ? 64'(cfg_len) : 64'd1;
        pos = pos_q;
        got = 1'b0;
        r = '0;
        bw = 64'(b);

        if (phase == gds_pkg::PH_HEAD && pos == 0) begin
            if (cfg_comp) begin
                block_fail(gds_pkg::ERR_COMPRESSED, r);
                got = 1'b1;
            end else if (!cfg_layout) begin
                if (len < n * 6) begin
                    block_fail(gds_pkg::ERR_TOO_SMALL, r);
                    got = 1'b1;
                end else begin
                    phase = (n != 0) ? gds_pkg::PH_D11 : gds_pkg::PH_DRAIN;
                end
            end else if (cfg_alleles != gds_pkg::BIALLELIC) begin
                block_fail(gds_pkg::ERR_NOT_BIALLELIC, r);
                got = 1'b1;
            end else if (len < 10) begin
                block_fail(gds_pkg::ERR_TOO_SMALL, r);
                got = 1'b1;
            end
        end
        ph0 = phase;

        if (ph0 == gds_pkg::PH_HEAD) begin
            refit = (64'(cfg_len) == n * 6);
            if (pos < 6) begin
                if (pos == 0) begin
                    hdr_win = 48'(bw);
                    smp_win = bw;
                end else begin
                    hdr_win = hdr_win | 48'(bw << (8 * pos));
                    smp_win = smp_win | (bw << (8 * pos));
                end
            end
            if (pos == 3) begin
                if (64'(hdr_win[31:0]) != n) begin
                    if (refit) begin
                        fallback = 1'b1;
                        phase = gds_pkg::PH_D11;
                    end else begin
                        block_fail(gds_pkg::ERR_SAMPLE_MISMATCH, r);
                        got = 1'b1;
                    end
                end
            end else if (pos == 5) begin
                if (hdr_win[47:32] != cfg_alleles) begin
                    if (refit) begin
                        fallback = 1'b1;
                        phase = gds_pkg::PH_D11;
                    end else begin
                        block_fail(gds_pkg::ERR_ALLELE_MISMATCH, r);
                        got = 1'b1;
                    end
                end
            end else if (pos == 7) begin
                if (n + 10 > len) begin
                    block_fail(gds_pkg::ERR_OVERRUN, r);
                    got = 1'b1;
                end
            end else if (pos >= 8) begin
                if (64'(pos) < n + 8) begin
                    if (pos - 20'd8 < 65536) marks[pos - 20'd8] = b[7];
                end else if (64'(pos) == n + 9) begin
                    if (b == 8) wcode = 2'd0;
                    else if (b == 16) wcode = 2'd1;
                    else if (b == 32) wcode = 2'd2;
                    if (b != 8 && b != 16 && b != 32) begin
                        block_fail(gds_pkg::ERR_BAD_WIDTH, r);
                        got = 1'b1;
                    end else if (n + 10 + n * (64'd2 << wcode) > len) begin
                        block_fail(gds_pkg::ERR_OVERRUN, r);
                        got = 1'b1;
                    end else begin
                        smp_cnt = '0;
                        phase = (n != 0) ? gds_pkg::PH_D12 : gds_pkg::PH_DRAIN;
                    end
                end else if (64'(pos) > n + 9) begin
                    phase = gds_pkg::PH_DRAIN;
                end
            end
        end

        if (phase == gds_pkg::PH_D11) begin
            off = 32'(pos % 20'd6);
            if (off == 0) smp_win = bw;
            else smp_win = smp_win | (bw << (8 * off));
            if (off == 5) begin
                aa = 64'(smp_win[15:0]);
                ab = 64'(smp_win[31:16]);
                bb = 64'(smp_win[47:32]);
                sum = aa + ab + bb;
                r = '0;
                r.idx = smp_cnt[15:0];
                r.st = gds_pkg::SS_MISSING;
                if (sum != 0) begin
                    r.dos = 32'(((ab + 2 * bb) << 30) / sum);
                    r.st = gds_pkg::SS_VALID;
                end
                smp_cnt = smp_cnt + 17'd1;
                if (64'(smp_cnt) >= n) phase = gds_pkg::PH_DRAIN;
                r.eob = (64'(smp_cnt) >= n);
                got = 1'b1;
            end
        end else if (ph0 == gds_pkg::PH_D12) begin
            nbytes = 1 << ((wcode > 2) ? 2 : wcode);
            stride = 2 * nbytes;
            off = 32'(64'(pos) - (n + 10)) % stride;
            if (off == 0) smp_win = bw;
            else smp_win = smp_win | (bw << (8 * off));
            if (off == stride - 1) begin
                bits = 8 * nbytes;
                m = (64'd1 << bits) - 1;
                aa = smp_win & m;
                ab = (smp_win >> bits) & m;
                miss = (smp_cnt < 65536) ? marks[smp_cnt[15:0]] : 1'b0;
                r = '0;
                r.idx = smp_cnt[15:0];
                if (miss) begin
                    r.st = gds_pkg::SS_MISSING;
                end else if (aa + ab > m) begin
                    r.st = gds_pkg::SS_INVALID;
                end else begin
                    bb = m - aa - ab;
                    r.dos = 32'(((ab + 2 * bb) << 30) / m);
                    r.st = gds_pkg::SS_VALID;
                end
                smp_cnt = smp_cnt + 17'd1;
                if (64'(smp_cnt) >= n) phase = gds_pkg::PH_DRAIN;
                r.eob = (64'(smp_cnt) >= n);
                got = 1'b1;
            end
        end

        if (64'(pos) + 1 >= len) begin
            if (got) r.eob = 1'b1;
            block_restart();
        end else begin
            pos_q = pos + 20'd1;
        end
        if (got) dosage_q = {dosage_q, r};
    endtask

    // acceptance on both sides, checking and watchdog
    always @(posedge i_clk) begin
        t_dosage act, want;
        bit moved;
        if (i_rst_n) begin
            moved = 0;
            if (in_ch.valid && in_ch.ready) begin
                decode_byte(in_ch.data_byte);
                took_cnt++;
                moved = 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                moved = 1;
                act = '{out_ch.sample_index, out_ch.dosage, out_ch.sample_status,
                        out_ch.error_code, out_ch.end_of_block};
                if (dosage_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected item: idx %0d dos %h st %0d err %0d eob %0d",
                             $time, act.idx, act.dos, act.st, act.err, act.eob);
                end else begin
                    want = dosage_q.pop_front();
                    if (act !== want) begin
                        fail_cnt++;
                        $display("%0t: mismatch expected idx %0d dos %h st %0d err %0d eob %0d",
                                 $time, want.idx, want.dos, want.st, want.err, want.eob);
                        $display("%0t:          actual   idx %0d dos %h st %0d err %0d eob %0d",
                                 $time, act.idx, act.dos, act.st, act.err, act.eob);
                    end
                end
            end
            if (moved) idle_cyc = 0;
            else idle_cyc++;
            if (idle_cyc >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cyc);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // byte driver
    always @(negedge i_clk) begin
        logic       nv;
        logic [7:0] nd;
        nv = in_ch.valid;
        nd = in_ch.data_byte;
        if (!i_rst_n) begin
            nv = 1'b0;
            nd = '0;
        end else if (!in_ch.valid || took_cnt != seen_cnt) begin
            seen_cnt = took_cnt;
            if (send_gap > 0) begin
                send_gap--;
                nv = 1'b0;
            end else if (byte_q.size() > 0) begin
                nv = 1'b1;
                nd = byte_q.pop_front();
                if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
            end else begin
                nv = 1'b0;
            end
        end
        in_ch.valid <= nv;
        in_ch.data_byte <= nd;
    end

    // result receiver: random stall bursts plus one long hold-off
    always @(negedge i_clk) begin
        logic rdy;
        if (hold_req && !hold_seen) begin
            hold_seen = 1;
            stall = HOLD_CYCLES;
        end
        if (stall > 0) begin
            stall--;
            rdy = 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall = $urandom_range(0, 15);
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        out_ch.ready <= rdy;
    end

    task automatic settle();
        while (byte_q.size() != 0 || in_ch.valid || dosage_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [gds_pkg::CFG_IDX_W-1:0] idx, input logic [19:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            gds_pkg::REG_LAYOUT:     cfg_layout = val[0];
            gds_pkg::REG_COMPRESSED: cfg_comp = val[0];
            gds_pkg::REG_SAMPLES:    cfg_samples = val[16:0];
            gds_pkg::REG_ALLELES:    cfg_alleles = val[15:0];
            gds_pkg::REG_BLOCK_LEN:  cfg_len = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_cfg(input logic lay, input logic comp, input logic [16:0] n,
                           input logic [15:0] al, input logic [19:0] len);
        settle();
        write_reg(gds_pkg::REG_LAYOUT, 20'(lay));
        write_reg(gds_pkg::REG_COMPRESSED, 20'(comp));
        write_reg(gds_pkg::REG_SAMPLES, 20'(n));
        write_reg(gds_pkg::REG_ALLELES, 20'(al));
        write_reg(gds_pkg::REG_BLOCK_LEN, len);
    endtask

    // bytes beyond the block length are dropped; finish_block pads short blocks
    task automatic put(input logic [7:0] b);
        if (blk_left > 0) begin
            byte_q = {byte_q, b};
            blk_left--;
            bytes_sent++;
        end
    endtask

    task automatic put_le(input logic [63:0] v, input int nb);
        for (int k = 0; k < nb; k++) put(v[8*k +: 8]);
    endtask

    task automatic start_block();
        blk_left = (cfg_len != 0) ? int'(cfg_len) : 1;
    endtask

    task automatic finish_block();
        while (blk_left > 0) put(8'($urandom));
    endtask

    task automatic noise_block();
        start_block();
        finish_block();
    endtask

    task automatic push_v12(input int n, input int wb, input logic [7:0] wbyte);
        logic [63:0] m, aa, ab;
        put_le(64'(n), 4);
        put_le(64'(gds_pkg::BIALLELIC), 2);
        put_le(64'($urandom), 2);
        repeat (n) put(($urandom_range(0, 3) == 0) ? (8'h80 | 8'($urandom))
                                                  : (8'h7f & 8'($urandom)));
        put(8'($urandom));
        put(wbyte);
        m = (64'd1 << (8 * wb)) - 1;
        repeat (n) begin
            case ($urandom_range(0, 7))
                0: begin aa = 0; ab = 0; end
                1: begin aa = m; ab = 0; end
                2: begin aa = 0; ab = m; end
                3: begin aa = m; ab = (64'($urandom) & m) | 64'd1; end
                default: begin
                    aa = 64'($urandom) & m;
                    ab = (64'($urandom) & m) % (m - aa + 1);
                end
            endcase
            put_le(aa, wb);
            put_le(ab, wb);
        end
    endtask

    task automatic push_v11(input int n);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0: put_le(64'd0, 6);
                1: put_le(64'hFFFF_FFFF_FFFF, 6);
                2: put_le(64'hFFFF_0000_0000, 6);
                default: put_le({16'd0, 16'($urandom), 32'($urandom)}, 6);
            endcase
        end
    endtask

    function automatic int v12_len(input int n, input int wb);
        return n + 10 + 2 * n * wb;
    endfunction

    initial begin
        int target, kind, n, wb, extra, len;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        cfg_layout = 1'b1;
        cfg_comp = 1'b0;
        cfg_samples = '0;
        cfg_alleles = gds_pkg::BIALLELIC;
        cfg_len = '0;
        block_restart();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero block length is a one-byte block, too small for layout 1.2
        noise_block();
        set_cfg(1'b1, 1'b1, 17'd2, gds_pkg::BIALLELIC, 20'd3);
        noise_block();
        set_cfg(1'b0, 1'b0, 17'd4, gds_pkg::BIALLELIC, 20'd5);
        noise_block();
        set_cfg(1'b0, 1'b0, 17'd65536, gds_pkg::BIALLELIC, 20'd1);
        noise_block();
        set_cfg(1'b1, 1'b0, 17'd1, 16'hFFFF, 20'd4);
        noise_block();
        set_cfg(1'b1, 1'b0, 17'd1, gds_pkg::BIALLELIC, 20'd9);
        noise_block();
        // header sample count and allele count mismatches without a 1.1 size match, then an overrun found in the header
        set_cfg(1'b1, 1'b0, 17'd3, gds_pkg::BIALLELIC, 20'd40);
        start_block(); put_le(64'd5, 4); finish_block();
        start_block(); put_le(64'd3, 4); put_le(64'd3, 2); finish_block();
        set_cfg(1'b1, 1'b0, 17'd3, gds_pkg::BIALLELIC, 20'd12);
        start_block(); put_le(64'd3, 4); put_le(64'(gds_pkg::BIALLELIC), 2); finish_block();
        // bad width byte, then an overrun found at the width byte
        set_cfg(1'b1, 1'b0, 17'd2, gds_pkg::BIALLELIC, 20'd40);
        start_block(); push_v12(2, 1, 8'd12); finish_block();
        start_block(); push_v12(2, 1, 8'd8); finish_block();
        set_cfg(1'b1, 1'b0, 17'd2, gds_pkg::BIALLELIC, 20'd15);
        start_block(); push_v12(2, 1, 8'd8); finish_block();
        // mismatched header with exactly six bytes per sample falls back to 1.1
        set_cfg(1'b1, 1'b0, 17'd3, gds_pkg::BIALLELIC, 20'd18);
        start_block(); push_v11(3); finish_block();
        start_block(); put_le(64'd3, 4); put_le(64'd9, 2); finish_block();
        // no samples: nothing comes out, but for the zero-length 1.2 block, which is too small
        set_cfg(1'b0, 1'b0, 17'd0, gds_pkg::BIALLELIC, 20'd0);
        noise_block();
        set_cfg(1'b1, 1'b0, 17'd0, gds_pkg::BIALLELIC, 20'd0);
        noise_block();
        set_cfg(1'b1, 1'b0, 17'd0, gds_pkg::BIALLELIC, 20'd12);
        start_block(); push_v12(0, 1, 8'd8); finish_block();
        for (int w = 1; w <= 4; w = w * 2) begin
            set_cfg(1'b1, 1'b0, 17'd4, gds_pkg::BIALLELIC, 20'(v12_len(4, w) + 2));
            start_block(); push_v12(4, w, 8'(8 * w)); finish_block();
        end
        set_cfg(1'b0, 1'b0, 17'd3, 16'hFFFF, 20'd20);
        start_block(); push_v11(3); finish_block();
        settle();
        write_reg(gds_pkg::REG_BLOCK_LEN, 20'hFFFFF);

        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            if (bytes_sent > target - 200) quiet = 1;
            kind = $urandom_range(0, 9);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
            wb = 1 << $urandom_range(0, 2);
            extra = $urandom_range(0, 3);
            if (kind <= 4) begin
                set_cfg(1'b1, 1'b0, 17'(n), gds_pkg::BIALLELIC, 20'(v12_len(n, wb) + extra));
                if (!hold_done && bytes_sent > target - RANDOM_BYTES / 2) begin
                    hold_done = 1;
                    hold_req = 1;
                end
                repeat ($urandom_range(1, 3)) begin
                    start_block(); push_v12(n, wb, 8'(8 * wb)); finish_block();
                end
            end else if (kind <= 6) begin
                set_cfg(1'b0, 1'b0, 17'(n), 16'($urandom), 20'(6 * n + extra));
                repeat ($urandom_range(1, 3)) begin
                    start_block(); push_v11(n); finish_block();
                end
            end else if (kind == 7) begin
                n = n + 1;
                set_cfg(1'b1, 1'b0, 17'(n), gds_pkg::BIALLELIC, 20'(6 * n));
                start_block();
                if ($urandom_range(0, 1)) push_v11(n);
                else begin put_le(64'(n), 4); put_le(64'($urandom_range(3, 65535)), 2); end
                finish_block();
            end else if (kind == 8) begin
                // broken 1.2 blocks: short length or a bad width byte
                len = v12_len(n, wb) - $urandom_range(1, 3);
                if ($urandom_range(0, 1)) begin
                    set_cfg(1'b1, 1'b0, 17'(n), gds_pkg::BIALLELIC, 20'(len));
                    start_block(); push_v12(n, wb, 8'(8 * wb)); finish_block();
                end else begin
                    set_cfg(1'b1, 1'b0, 17'(n), gds_pkg::BIALLELIC, 20'(len + 8));
                    start_block(); push_v12(n, wb, 8'($urandom)); finish_block();
                end
            end else begin
                set_cfg(1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0),
                        17'($urandom_range(0, 8)),
                        ($urandom_range(0, 3) == 0) ? 16'($urandom) : gds_pkg::BIALLELIC,
                        20'($urandom_range(0, 40)));
                repeat ($urandom_range(1, 3)) noise_block();
            end
        end

        settle();
        if (fail_cnt == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/gds_pkg.sv
rtl/core/gds_in_if.sv
rtl/core/gds_out_if.sv
rtl/core/gds_ctrl.sv
rtl/core/gds_datapath.sv
rtl/core/genotype_dosage_stream_core.sv
sim/genotype_dosage_stream_core_tb.sv
